/* design/middle_insert_indexed_queue_unit_defines.svh */
// Assertion macros shared by the middle insert indexed queue modules.
`ifndef MIDDLE_INSERT_INDEXED_QUEUE_UNIT_DEFINES_SVH
`define MIDDLE_INSERT_INDEXED_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MIQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define MIQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MIQ_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define MIQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/miq_pkg.sv */
// Package: item types, codes and control types of the middle insert indexed queue.
`timescale 1ns / 1ps
package miq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH_BACK   = 2'd0,
        CMD_PUSH_FRONT  = 2'd1,
        CMD_PUSH_MIDDLE = 2'd2,
        CMD_READ        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t               command;
        logic signed [31:0] element;
        logic [9:0]         index;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        status_t            status;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_MOVE = 2'd2
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
        logic load_out;
    } ctrl_cmd_t;

endpackage

/* design/miq_controller.sv */
// Controller: sequences accept, execute, memory move and result load of each item.
`timescale 1ns / 1ps
`include "middle_insert_indexed_queue_unit_defines.svh"
module miq_controller
    import miq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  logic      two_cycle,
    output ctrl_cmd_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (two_cycle)
                begin
                    state_next = ST_MOVE;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOVE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        ctrl.capture  = 1'b0;
        ctrl.exec     = 1'b0;
        ctrl.finish   = 1'b0;
        ctrl.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                ctrl.capture = req_valid;
            end
            ST_EXEC:
            begin
                ctrl.exec     = two_cycle || out_free;
                ctrl.load_out = !two_cycle && out_free;
            end
            ST_MOVE:
            begin
                ctrl.finish   = out_free;
                ctrl.load_out = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    `MIQ_ASSERT_IMPLIES(a_load_into_free_slot, clk, rst_n, ctrl.load_out, out_free)
    `MIQ_ASSERT_NEXT(a_move_follows_read, clk, rst_n, (state_reg == ST_EXEC) && two_cycle, state_reg == ST_MOVE)
    `MIQ_ASSERT_NEXT(a_load_shows_result, clk, rst_n, ctrl.load_out, out_valid_reg)

endmodule

/* design/miq_datapath.sv */
// Datapath: two ring memories, heads, counts, item register and result register.
`timescale 1ns / 1ps
`include "middle_insert_indexed_queue_unit_defines.svh"
module miq_datapath
    import miq_pkg::*;
#(
    parameter int HALF_DEPTH = 512
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_item_t req_item,
    input  ctrl_cmd_t ctrl,
    output logic      two_cycle,
    output rsp_item_t rsp_item
);

    localparam int HW = $clog2(HALF_DEPTH);
    localparam int CW = $clog2(HALF_DEPTH + 1);
    localparam int TW = $clog2(2 * HALF_DEPTH + 1);
    localparam int XW = (TW > 10) ? TW : 10;
    localparam logic [HW-1:0] LAST_ADDR = HW'(HALF_DEPTH - 1);

    function automatic logic [HW-1:0] wrap_add(logic [HW-1:0] base, logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW + 1 - HW){1'b0}}, base} + {1'b0, off};
        if (sum >= (CW + 1)'(HALF_DEPTH))
        begin
            sum = sum - (CW + 1)'(HALF_DEPTH);
        end
        return sum[HW-1:0];
    endfunction

    logic [31:0]   front_mem [HALF_DEPTH];
    logic [31:0]   back_mem  [HALF_DEPTH];
    logic [31:0]   front_rdata_reg;
    logic [31:0]   back_rdata_reg;

    logic [HW-1:0] front_head_reg,  front_head_next;
    logic [CW-1:0] front_count_reg, front_count_next;
    logic [HW-1:0] back_head_reg,   back_head_next;
    logic [CW-1:0] back_count_reg,  back_count_next;
    req_item_t     item_reg;
    rsp_item_t     rsp_reg, rsp_next;

    logic          fw_en, bw_en, fr_en, br_en;
    logic [HW-1:0] fw_addr, bw_addr, fr_addr, br_addr;
    logic [31:0]   fw_data, bw_data;

    logic [TW-1:0] total;
    logic [XW-1:0] idx_x, total_x, fc_x, back_off_x;
    logic          full, is_read, oor, in_front, push_ok;
    logic          fc_eq_bc, fc_eq_bc1, move_from_back, move_from_front;
    logic [HW-1:0] front_dec, back_dec, back_inc;
    logic [CW-1:0] fc_minus1;
    logic [31:0]   read_sel;

    assign total      = TW'(front_count_reg) + TW'(back_count_reg);
    assign idx_x      = XW'(item_reg.index);
    assign total_x    = XW'(total);
    assign fc_x       = XW'(front_count_reg);
    assign back_off_x = idx_x - fc_x;
    assign full       = (total == TW'(2 * HALF_DEPTH));
    assign is_read    = (item_reg.command == CMD_READ);
    assign oor        = (idx_x >= total_x);
    assign in_front   = (idx_x < fc_x);
    assign push_ok    = !is_read && !full;
    assign fc_eq_bc   = (front_count_reg == back_count_reg);
    assign fc_eq_bc1  = ({1'b0, front_count_reg} == ({1'b0, back_count_reg} + (CW + 1)'(1)));
    assign move_from_back  = (item_reg.command == CMD_PUSH_BACK) && fc_eq_bc
                             && (back_count_reg != '0);
    assign move_from_front = (item_reg.command == CMD_PUSH_FRONT) && fc_eq_bc1;
    assign front_dec  = (front_head_reg == '0) ? LAST_ADDR : front_head_reg - HW'(1);
    assign back_dec   = (back_head_reg == '0) ? LAST_ADDR : back_head_reg - HW'(1);
    assign back_inc   = (back_head_reg == LAST_ADDR) ? '0 : back_head_reg + HW'(1);
    assign fc_minus1  = front_count_reg - CW'(1);
    assign read_sel   = in_front ? front_rdata_reg : back_rdata_reg;
    assign two_cycle  = (is_read && !oor) || (push_ok && (move_from_back || move_from_front));

    always_comb
    begin
        front_head_next  = front_head_reg;
        front_count_next = front_count_reg;
        back_head_next   = back_head_reg;
        back_count_next  = back_count_reg;
        fw_en   = 1'b0;
        fw_addr = '0;
        fw_data = '0;
        bw_en   = 1'b0;
        bw_addr = '0;
        bw_data = '0;
        fr_en   = 1'b0;
        fr_addr = '0;
        br_en   = 1'b0;
        br_addr = '0;
        if (ctrl.exec)
        begin
            case (item_reg.command)
                CMD_READ:
                begin
                    if (!oor && in_front)
                    begin
                        fr_en   = 1'b1;
                        fr_addr = wrap_add(front_head_reg, idx_x[CW-1:0]);
                    end
                    else if (!oor)
                    begin
                        br_en   = 1'b1;
                        br_addr = wrap_add(back_head_reg, back_off_x[CW-1:0]);
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (!full && move_from_back)
                    begin
                        br_en   = 1'b1;
                        br_addr = back_head_reg;
                    end
                    else if (!full && fc_eq_bc)
                    begin
                        fw_en            = 1'b1;
                        fw_addr          = wrap_add(front_head_reg, front_count_reg);
                        fw_data          = item_reg.element;
                        front_count_next = front_count_reg + CW'(1);
                    end
                    else if (!full)
                    begin
                        bw_en           = 1'b1;
                        bw_addr         = wrap_add(back_head_reg, back_count_reg);
                        bw_data         = item_reg.element;
                        back_count_next = back_count_reg + CW'(1);
                    end
                end
                CMD_PUSH_FRONT:
                begin
                    if (!full && move_from_front)
                    begin
                        fr_en   = 1'b1;
                        fr_addr = wrap_add(front_head_reg, fc_minus1);
                    end
                    else if (!full)
                    begin
                        fw_en            = 1'b1;
                        fw_addr          = front_dec;
                        fw_data          = item_reg.element;
                        front_head_next  = front_dec;
                        front_count_next = front_count_reg + CW'(1);
                    end
                end
                CMD_PUSH_MIDDLE:
                begin
                    if (!full && (front_count_reg <= back_count_reg))
                    begin
                        fw_en            = 1'b1;
                        fw_addr          = wrap_add(front_head_reg, front_count_reg);
                        fw_data          = item_reg.element;
                        front_count_next = front_count_reg + CW'(1);
                    end
                    else if (!full)
                    begin
                        bw_en           = 1'b1;
                        bw_addr         = back_dec;
                        bw_data         = item_reg.element;
                        back_head_next  = back_dec;
                        back_count_next = back_count_reg + CW'(1);
                    end
                end
                default:
                begin
                    fw_en = 1'b0;
                end
            endcase
        end
        if (ctrl.finish && push_ok && move_from_back)
        begin
            fw_en            = 1'b1;
            fw_addr          = wrap_add(front_head_reg, front_count_reg);
            fw_data          = back_rdata_reg;
            bw_en            = 1'b1;
            bw_addr          = wrap_add(back_head_reg, back_count_reg);
            bw_data          = item_reg.element;
            back_head_next   = back_inc;
            front_count_next = front_count_reg + CW'(1);
        end
        else if (ctrl.finish && push_ok && move_from_front)
        begin
            bw_en           = 1'b1;
            bw_addr         = back_dec;
            bw_data         = front_rdata_reg;
            back_head_next  = back_dec;
            back_count_next = back_count_reg + CW'(1);
            fw_en           = 1'b1;
            fw_addr         = front_dec;
            fw_data         = item_reg.element;
            front_head_next = front_dec;
        end
    end

    always_comb
    begin
        rsp_next.read_value = (ctrl.finish && is_read) ? read_sel : '0;
        if (is_read)
        begin
            rsp_next.status = oor ? STATUS_RANGE : STATUS_OK;
        end
        else
        begin
            rsp_next.status = full ? STATUS_FULL : STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fw_en)
        begin
            front_mem[fw_addr] <= fw_data;
        end
        if (fr_en)
        begin
            front_rdata_reg <= front_mem[fr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bw_en)
        begin
            back_mem[bw_addr] <= bw_data;
        end
        if (br_en)
        begin
            back_rdata_reg <= back_mem[br_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg <= req_item;
        end
        if (ctrl.load_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_head_reg  <= '0;
            front_count_reg <= '0;
            back_head_reg   <= '0;
            back_count_reg  <= '0;
        end
        else
        begin
            front_head_reg  <= front_head_next;
            front_count_reg <= front_count_next;
            back_head_reg   <= back_head_next;
            back_count_reg  <= back_count_next;
        end
    end

    assign rsp_item = rsp_reg;

    `MIQ_ASSERT_ALWAYS(a_halves_balanced, clk, rst_n, fc_eq_bc || fc_eq_bc1)
    `MIQ_ASSERT_ALWAYS(a_heads_in_ring, clk, rst_n, (front_head_reg <= LAST_ADDR) && (back_head_reg <= LAST_ADDR))
    `MIQ_ASSERT_NEXT(a_read_keeps_counts, clk, rst_n, fr_en || br_en, $stable(front_count_reg) && $stable(back_count_reg))

endmodule

/* design/middle_insert_indexed_queue_unit.sv */
// Top level of the middle insert indexed queue: controller and datapath.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_ready | req_item (command, element, index)
//  rsp     | out       | rsp_valid, rsp_ready | rsp_item (read_value, status)
//
// A push that needs no rebalancing steps through accept, then execute.
// An in-range read and a rebalancing push add a move step for the registered memory read.
// Reset zeroes heads and counts; the ring memories are not cleared.
// A finished result waits in the output register; the next item is accepted meanwhile
// and holds in its last step until that register is free.
`timescale 1ns / 1ps
module middle_insert_indexed_queue_unit
    import miq_pkg::*;
#(
    parameter int HALF_DEPTH = 512
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_item
);

    ctrl_cmd_t ctrl;
    logic      two_cycle;

    miq_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .two_cycle (two_cycle),
        .ctrl      (ctrl)
    );

    miq_datapath #(
        .HALF_DEPTH (HALF_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .ctrl      (ctrl),
        .two_cycle (two_cycle),
        .rsp_item  (rsp_item)
    );

endmodule

/* test/testbench.sv */
// Self-checking bench for the middle insert indexed queue: directed and random pushes and reads.
`timescale 1ns / 1ps
module testbench
    import miq_pkg::*;
();

    localparam int CAPACITY     = 1024;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_HICCUP
    } rx_mode_t;

    class indexed_queue_shadow;
        logic signed [31:0] elements[$];
        rsp_item_t          awaited_rsp[$];
        int                 mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void accept_request(req_item_t it);
            rsp_item_t r;
            int        total;
            total        = elements.size();
            r.read_value = '0;
            r.status     = STATUS_OK;
            if (it.command == CMD_READ)
            begin
                if (it.index >= total)
                    r.status = STATUS_RANGE;
                else
                    r.read_value = elements[it.index];
            end
            else if (total >= CAPACITY)
            begin
                r.status = STATUS_FULL;
            end
            else if (it.command == CMD_PUSH_BACK)
            begin
                elements.insert(total, it.element);
            end
            else if (it.command == CMD_PUSH_FRONT)
            begin
                elements.insert(0, it.element);
            end
            else
            begin
                // middle lands right after the front half, which holds ceil(total / 2)
                elements.insert((total + 1) / 2, it.element);
            end
            awaited_rsp.insert(awaited_rsp.size(), r);
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (awaited_rsp.size() == 0)
            begin
                $error("unexpected item: read_value %0d status %0d",
                       got.read_value, got.status);
                mismatches++;
                return;
            end
            want = awaited_rsp[0];
            awaited_rsp.delete(0);
            if (got.read_value !== want.read_value)
            begin
                $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    req_item_t           req_item  = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_item_t           rsp_item;
    int unsigned         cycles    = 0;
    rx_mode_t            rx_mode   = RX_STEADY;
    indexed_queue_shadow shadow    = new();

    middle_insert_indexed_queue_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            shadow.check_response(rsp_item);
        if (cycles % 150 == 0)
        begin
            case ($urandom_range(0, 3))
                0:       rx_mode <= RX_STEADY;
                1:       rx_mode <= RX_COIN;
                2:       rx_mode <= RX_SPARSE;
                default: rx_mode <= RX_HICCUP;
            endcase
        end
        case (rx_mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= (cycles % 4 == 0);
            default:   rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_item(input cmd_t command, input logic signed [31:0] element,
                             input logic [9:0] index);
        req_item_t it;
        it.command = command;
        it.element = element;
        it.index   = index;
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        shadow.accept_request(it);
    endtask

    task automatic idle(input int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (shadow.awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                 sent;
        int                 burst;
        int                 total;
        int                 pick;
        cmd_t               command;
        logic signed [31:0] element;
        logic [9:0]         index;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue reads, then every rebalancing path
        send_item(CMD_READ, '0, 10'd0);
        send_item(CMD_READ, '1, 10'd1023);
        send_item(CMD_PUSH_MIDDLE, 32'h7FFFFFFF, 10'd1023);
        send_item(CMD_PUSH_BACK, 32'h80000000, 10'd0);
        send_item(CMD_PUSH_FRONT, 32'hFFFFFFFF, 10'd0);
        send_item(CMD_PUSH_MIDDLE, 32'h00000000, 10'd0);
        send_item(CMD_PUSH_BACK, 32'h55555555, 10'd0);
        send_item(CMD_PUSH_FRONT, 32'hAAAAAAAA, 10'd0);
        send_item(CMD_PUSH_MIDDLE, 32'h00000001, 10'd0);
        for (int i = 0; i < 7; i++)
            send_item(CMD_READ, '0, 10'(i));
        send_item(CMD_READ, '0, 10'd7);
        send_item(CMD_READ, '0, 10'd1023);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < RANDOM_ITEMS)
            begin
                total = shadow.elements.size();
                pick  = $urandom_range(0, 99);
                if (pick < ((total >= CAPACITY) ? 50 : 30))
                    command = CMD_READ;
                else if (pick % 3 == 0)
                    command = CMD_PUSH_BACK;
                else if (pick % 3 == 1)
                    command = CMD_PUSH_FRONT;
                else
                    command = CMD_PUSH_MIDDLE;
                case ($urandom_range(0, 15))
                    0:       element = 32'h7FFFFFFF;
                    1:       element = 32'h80000000;
                    2:       element = '0;
                    3:       element = '1;
                    default: element = $urandom();
                endcase
                pick  = $urandom_range(0, 19);
                index = 10'($urandom_range(0, 1023));
                if (total > 0 && pick < 15)
                    index = 10'($urandom_range(0, total - 1));
                else if (pick < 18)
                    index = 10'($urandom_range((total < 1023) ? total : 1023,
                                               (total + 3 < 1023) ? total + 3 : 1023));
                send_item(command, element, index);
                sent++;
                burst--;
                if (sent == RANDOM_ITEMS / 2)
                    wait_drained();
            end
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 8));
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.awaited_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
